// ===== design/affine_rect_bounds_unit_defines.svh =====
// ----------------------------------------------------------------------------
// affine_rect_bounds_unit_defines.svh
// Assertion macros shared by the affine rectangle bounds unit.
// ----------------------------------------------------------------------------
`ifndef AFFINE_RECT_BOUNDS_UNIT_DEFINES_SVH
`define AFFINE_RECT_BOUNDS_UNIT_DEFINES_SVH

// Clocked assertion, ignored while reset is active
`define ARB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define ARB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/arb_pkg.sv =====
// ----------------------------------------------------------------------------
// arb_pkg
// Types, constants and register codes of the affine rectangle bounds unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package arb_pkg;

    // Coordinate and coefficient width (signed fixed point)
    localparam int COORD_W = 32;
    // Default number of fraction bits
    localparam int FRAC_BITS_DEF = 16;
    // Configuration index width
    localparam int CFG_IDX_W = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [COORD_W-1:0]        t_ucoord;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_A   = 3'd0,
        CFG_COEF_B   = 3'd1,
        CFG_COEF_C   = 3'd2,
        CFG_COEF_D   = 3'd3,
        CFG_OFFSET_X = 3'd4,
        CFG_OFFSET_Y = 3'd5
    } t_cfg_idx;

    // Matrix and translation
    typedef struct packed {
        t_coord coef_a;
        t_coord coef_b;
        t_coord coef_c;
        t_coord coef_d;
        t_coord offset_x;
        t_coord offset_y;
    } t_matrix;

    // Input transaction
    typedef struct packed {
        t_coord rect_x;
        t_coord rect_y;
        t_coord rect_width;
        t_coord rect_height;
    } t_rect_in;

    // Result transaction
    typedef struct packed {
        t_coord  bound_min_x;
        t_coord  bound_min_y;
        t_ucoord bound_width;
        t_ucoord bound_height;
    } t_bound_out;

    // Both edges of the rectangle on each axis
    typedef struct packed {
        t_coord x0;
        t_coord x1;
        t_coord y0;
        t_coord y1;
    } t_corner_span;

    // Mapped corners: index bit 0 picks x1, bit 1 picks y1
    typedef struct packed {
        t_coord [3:0] cx;
        t_coord [3:0] cy;
    } t_mapped;

endpackage

`default_nettype wire

// ===== design/arb_corner.sv =====
// ----------------------------------------------------------------------------
// arb_corner
// Saturating far-edge stage: forms origin plus size on each axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arb_corner (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire arb_pkg::t_rect_in     i_rect,
    output logic                       o_valid,
    output arb_pkg::t_corner_span      o_span
);

    localparam int W = arb_pkg::COORD_W;

    logic                   r_valid;
    arb_pkg::t_corner_span  r_span;
    arb_pkg::t_corner_span  n_span;
    logic signed [W:0]      sum_x;
    logic signed [W:0]      sum_y;

    // Saturate a one-bit-grown sum back to the coordinate range
    function automatic arb_pkg::t_coord sat_grow(input logic signed [W:0] v);
        logic ovf;
        ovf = v[W] ^ v[W-1];
        if (!ovf) begin
            sat_grow = v[W-1:0];
        end else if (v[W]) begin
            sat_grow = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_grow = {1'b0, {(W-1){1'b1}}};
        end
    endfunction

    // Add size to origin on each axis
    always_comb begin
        sum_x         = (W+1)'(i_rect.rect_x) + (W+1)'(i_rect.rect_width);
        sum_y         = (W+1)'(i_rect.rect_y) + (W+1)'(i_rect.rect_height);
        n_span.x0     = i_rect.rect_x;
        n_span.y0     = i_rect.rect_y;
        n_span.x1     = sat_grow(sum_x);
        n_span.y1     = sat_grow(sum_y);
    end

    // Advance valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_span <= n_span;
    end

    assign o_valid = r_valid;
    assign o_span  = r_span;

endmodule

`default_nettype wire

// ===== design/arb_mapper.sv =====
// ----------------------------------------------------------------------------
// arb_mapper
// Two-stage affine map of the four corners: products, then sum and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module arb_mapper #(
    parameter int FRAC_BITS = arb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire arb_pkg::t_matrix      i_matrix,
    input  wire logic                  i_valid,
    input  wire arb_pkg::t_corner_span i_span,
    output logic                       o_valid,
    output arb_pkg::t_mapped           o_mapped
);

    localparam int W      = arb_pkg::COORD_W;
    localparam int PROD_W = 2 * W;
    localparam int SHP_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = SHP_W + 2;

    typedef logic signed [SHP_W-1:0] t_shp;
    typedef logic signed [SUM_W-1:0] t_sum;

    // Products indexed by edge: 0 for origin, 1 for far edge
    logic               r_valid_p;
    t_shp [1:0]         r_ax, r_cy, r_bx, r_dy;
    t_shp [1:0]         n_ax, n_cy, n_bx, n_dy;
    logic signed [PROD_W-1:0] p_ax [2];
    logic signed [PROD_W-1:0] p_cy [2];
    logic signed [PROD_W-1:0] p_bx [2];
    logic signed [PROD_W-1:0] p_dy [2];

    logic               r_valid_s;
    arb_pkg::t_mapped   r_mapped;
    arb_pkg::t_mapped   n_mapped;
    t_sum               sum_x [4];
    t_sum               sum_y [4];

    // Saturate a wide sum to the coordinate range
    function automatic arb_pkg::t_coord sat_sum(input t_sum v);
        t_sum hi;
        t_sum lo;
        hi = SUM_W'({1'b0, {(W-1){1'b1}}});
        lo = -hi - SUM_W'(1);
        if (v > hi) begin
            sat_sum = {1'b0, {(W-1){1'b1}}};
        end else if (v < lo) begin
            sat_sum = {1'b1, {(W-1){1'b0}}};
        end else begin
            sat_sum = v[W-1:0];
        end
    endfunction

    // Form products and drop fraction bits toward minus infinity
    always_comb begin
        p_ax[0] = i_matrix.coef_a * i_span.x0;
        p_ax[1] = i_matrix.coef_a * i_span.x1;
        p_cy[0] = i_matrix.coef_c * i_span.y0;
        p_cy[1] = i_matrix.coef_c * i_span.y1;
        p_bx[0] = i_matrix.coef_b * i_span.x0;
        p_bx[1] = i_matrix.coef_b * i_span.x1;
        p_dy[0] = i_matrix.coef_d * i_span.y0;
        p_dy[1] = i_matrix.coef_d * i_span.y1;
        for (int e = 0; e < 2; e++) begin
            n_ax[e] = SHP_W'(p_ax[e] >>> FRAC_BITS);
            n_cy[e] = SHP_W'(p_cy[e] >>> FRAC_BITS);
            n_bx[e] = SHP_W'(p_bx[e] >>> FRAC_BITS);
            n_dy[e] = SHP_W'(p_dy[e] >>> FRAC_BITS);
        end
    end

    // Sum products with the offset and saturate each corner
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            sum_x[k] = SUM_W'(r_ax[k % 2]) + SUM_W'(r_cy[k / 2])
                     + SUM_W'(i_matrix.offset_x);
            sum_y[k] = SUM_W'(r_bx[k % 2]) + SUM_W'(r_dy[k / 2])
                     + SUM_W'(i_matrix.offset_y);
            n_mapped.cx[k] = sat_sum(sum_x[k]);
            n_mapped.cy[k] = sat_sum(sum_y[k]);
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_p <= 1'b0;
            r_valid_s <= 1'b0;
        end else begin
            r_valid_p <= i_valid;
            r_valid_s <= r_valid_p;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_ax     <= n_ax;
        r_cy     <= n_cy;
        r_bx     <= n_bx;
        r_dy     <= n_dy;
        r_mapped <= n_mapped;
    end

    assign o_valid  = r_valid_s;
    assign o_mapped = r_mapped;

endmodule

`default_nettype wire

// ===== design/arb_bounds.sv =====
// ----------------------------------------------------------------------------
// arb_bounds
// Registered min/max tree over the mapped corners and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "affine_rect_bounds_unit_defines.svh"

module arb_bounds (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire arb_pkg::t_mapped  i_mapped,
    output logic                   o_valid,
    output arb_pkg::t_bound_out    o_bound
);

    // First tree level: pairs (0,1) and (2,3)
    logic                 r_valid_1;
    arb_pkg::t_coord      r_mnx [2], r_mxx [2], r_mny [2], r_mxy [2];
    arb_pkg::t_coord      n_mnx [2], n_mxx [2], n_mny [2], n_mxy [2];

    // Second tree level
    logic                 r_valid_2;
    arb_pkg::t_coord      r_min_x, r_max_x, r_min_y, r_max_y;
    arb_pkg::t_coord      n_min_x, n_max_x, n_min_y, n_max_y;

    // Output register
    logic                 r_valid_o;
    arb_pkg::t_bound_out  r_bound;
    arb_pkg::t_bound_out  n_bound;

    // Compare corner pairs
    always_comb begin
        for (int p = 0; p < 2; p++) begin
            if (i_mapped.cx[2*p] < i_mapped.cx[2*p+1]) begin
                n_mnx[p] = i_mapped.cx[2*p];
                n_mxx[p] = i_mapped.cx[2*p+1];
            end else begin
                n_mnx[p] = i_mapped.cx[2*p+1];
                n_mxx[p] = i_mapped.cx[2*p];
            end
            if (i_mapped.cy[2*p] < i_mapped.cy[2*p+1]) begin
                n_mny[p] = i_mapped.cy[2*p];
                n_mxy[p] = i_mapped.cy[2*p+1];
            end else begin
                n_mny[p] = i_mapped.cy[2*p+1];
                n_mxy[p] = i_mapped.cy[2*p];
            end
        end
    end

    // Merge the pair results
    always_comb begin
        n_min_x = (r_mnx[0] < r_mnx[1]) ? r_mnx[0] : r_mnx[1];
        n_max_x = (r_mxx[0] > r_mxx[1]) ? r_mxx[0] : r_mxx[1];
        n_min_y = (r_mny[0] < r_mny[1]) ? r_mny[0] : r_mny[1];
        n_max_y = (r_mxy[0] > r_mxy[1]) ? r_mxy[0] : r_mxy[1];
    end

    // Form box origin and extent
    always_comb begin
        n_bound.bound_min_x  = r_min_x;
        n_bound.bound_min_y  = r_min_y;
        n_bound.bound_width  = arb_pkg::t_ucoord'(r_max_x - r_min_x);
        n_bound.bound_height = arb_pkg::t_ucoord'(r_max_y - r_min_y);
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_1 <= 1'b0;
            r_valid_2 <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            r_valid_1 <= i_valid;
            r_valid_2 <= r_valid_1;
            r_valid_o <= r_valid_2;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_mnx   <= n_mnx;
        r_mxx   <= n_mxx;
        r_mny   <= n_mny;
        r_mxy   <= n_mxy;
        r_min_x <= n_min_x;
        r_max_x <= n_max_x;
        r_min_y <= n_min_y;
        r_max_y <= n_max_y;
        r_bound <= n_bound;
    end

    assign o_valid = r_valid_o;
    assign o_bound = r_bound;

    // The merged extremes are ordered, and the extent follows them
    `ARB_ASSERT(a_x_ordered, r_valid_2 |-> (r_max_x >= r_min_x), "x extremes out of order")
    `ARB_ASSERT(a_y_ordered, r_valid_2 |-> (r_max_y >= r_min_y), "y extremes out of order")
    `ARB_ASSERT(a_width_tracks, r_valid_o |-> (r_bound.bound_width == arb_pkg::t_ucoord'($past(r_max_x) - $past(r_min_x))), "width does not match extremes")

endmodule

`default_nettype wire

// ===== design/affine_rect_bounds_unit.sv =====
// ----------------------------------------------------------------------------
// affine_rect_bounds_unit
// Bounding box of an affine-mapped rectangle, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Configure the matrix through i_cfg_we / i_cfg_idx / i_cfg_wdata while no
//   transaction is in flight: indexes 0..5 are coef_a, coef_b, coef_c, coef_d,
//   offset_x, offset_y (signed fixed point); other indexes are ignored.
//   Present a rectangle on i_rect and raise i_start; it is taken at any edge
//   with i_start high, since o_busy stays low: one transaction per cycle.
//   The box comes out on o_bound with o_done high for exactly one cycle,
//   in order of acceptance. The pipeline has six register stages:
//   far-edge saturation, eight multipliers, corner sums with saturation,
//   two min/max levels and the output register. Throughput is one transaction
//   every cycle. The receiver has no way to stall; it must take o_bound when
//   o_done is high. Synchronous reset clears every valid bit (no result is
//   pending) and restores the identity matrix with zero offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "affine_rect_bounds_unit_defines.svh"

module affine_rect_bounds_unit #(
    parameter int FRAC_BITS = arb_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [arb_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire logic [arb_pkg::COORD_W-1:0]       i_cfg_wdata,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire arb_pkg::t_rect_in                 i_rect,
    output logic                                   o_done,
    output arb_pkg::t_bound_out                    o_bound
);

    localparam arb_pkg::t_coord ONE = arb_pkg::t_coord'(1) << FRAC_BITS;

    arb_pkg::t_matrix       r_matrix;
    arb_pkg::t_matrix       n_matrix;
    logic                   accept;
    logic                   span_valid;
    arb_pkg::t_corner_span  span;
    logic                   map_valid;
    arb_pkg::t_mapped       mapped;

    // Pipeline never stalls
    assign o_busy = 1'b0;
    assign accept = i_start & ~o_busy;

    // Decode configuration writes
    always_comb begin
        n_matrix = r_matrix;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                arb_pkg::CFG_COEF_A:   n_matrix.coef_a   = i_cfg_wdata;
                arb_pkg::CFG_COEF_B:   n_matrix.coef_b   = i_cfg_wdata;
                arb_pkg::CFG_COEF_C:   n_matrix.coef_c   = i_cfg_wdata;
                arb_pkg::CFG_COEF_D:   n_matrix.coef_d   = i_cfg_wdata;
                arb_pkg::CFG_OFFSET_X: n_matrix.offset_x = i_cfg_wdata;
                arb_pkg::CFG_OFFSET_Y: n_matrix.offset_y = i_cfg_wdata;
                default:               n_matrix          = r_matrix;
            endcase
        end
    end

    // Hold matrix, identity after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix.coef_a   <= ONE;
            r_matrix.coef_b   <= '0;
            r_matrix.coef_c   <= '0;
            r_matrix.coef_d   <= ONE;
            r_matrix.offset_x <= '0;
            r_matrix.offset_y <= '0;
        end else begin
            r_matrix <= n_matrix;
        end
    end

    arb_corner u_corner (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_rect  (i_rect),
        .o_valid (span_valid),
        .o_span  (span)
    );

    arb_mapper #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mapper (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_matrix (r_matrix),
        .i_valid  (span_valid),
        .i_span   (span),
        .o_valid  (map_valid),
        .o_mapped (mapped)
    );

    arb_bounds u_bounds (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (map_valid),
        .i_mapped (mapped),
        .o_valid  (o_done),
        .o_bound  (o_bound)
    );

    // Every accepted transaction returns a result, and no result comes without one
    `ARB_ASSERT(a_start_done, accept |-> ##6 o_done, "accepted transaction lost")
    `ARB_ASSERT(a_done_start, o_done |-> $past(accept, 6), "result without transaction")
    `ARB_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_done, "result pending after reset")

endmodule

`default_nettype wire
